// ----- rtl/tccw_pkg.sv -----
`default_nettype none

package tccw_pkg;

    // Field widths of the stream payloads
    localparam int ACT_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int LOC_W    = 11;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // Actions
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Register indexes
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

    // Reset values
    localparam logic [CELL_W-1:0]  RESET_CELL = 16'h0F20;
    localparam logic [COLOR_W-1:0] FG_RESET   = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET   = 4'h0;

endpackage

`default_nettype wire

// ----- rtl/tccw_ram.sv -----
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/text_console_char_writer_unit.sv -----
// Channel   | ports                  | tdata fields (low bit up)
// ----------+------------------------+-----------------------------------------------
// input     | s_tvalid/tready/tdata  | action[1:0] char_code[9:2] cell_index[20:10]
// result    | m_tvalid/tready/tdata  | cursor_location[10:0] read_data[26:11] scrolled[27]
// config    | cfg_we/index/data      | 0 fg_color, 1 bg_color
//
// One item at a time: write, read and idle items pass through accept and result load.
// A scroll adds a sweep that blanks one row; the screen is a ring of rows in one
// RAM, so no row is copied. A clear sweeps every cell, one cell per cycle.
// After reset a fill pass writes the blank cell everywhere; no item is accepted then.
// The result register lets an item enter while the last result waits; a stalled
// result output holds the next one in the load cycle.
`default_nettype none

module text_console_char_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // action, char_code, cell_index
    input  wire logic [tccw_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // cursor_location, read_data, scrolled
    output logic      [tccw_pkg::M_DATA_W-1:0]     m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [tccw_pkg::COLOR_W-1:0]      cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 8);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int IW    = tccw_pkg::IDX_W;
    localparam int SW    = ((AW > IW) ? AW : IW) + 1;
    localparam int PAD_W = tccw_pkg::M_DATA_W - tccw_pkg::LOC_W - tccw_pkg::CELL_W - 1;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                          state_reg;
    logic [CW-1:0]                   col_reg;
    logic [RW-1:0]                   row_reg;
    logic [AW-1:0]                   top_base_reg;
    logic [AW-1:0]                   sweep_addr_reg;
    logic [AW-1:0]                   sweep_last_reg;
    logic [tccw_pkg::COLOR_W-1:0]    fg_reg;
    logic [tccw_pkg::COLOR_W-1:0]    bg_reg;
    logic                            m_tvalid_reg;
    logic [tccw_pkg::M_DATA_W-1:0]   m_tdata_reg;
    logic [tccw_pkg::LOC_W-1:0]      res_loc_reg;
    logic                            res_rd_reg;
    logic                            res_scr_reg;

    logic [tccw_pkg::ACT_W-1:0]      in_action;
    logic [tccw_pkg::CHAR_W-1:0]     in_char;
    logic [IW-1:0]                   in_idx;
    logic                            accept;

    logic [CW-1:0]                   col_next;
    logic [RW-1:0]                   row_next;
    logic                            put_char;
    logic                            scroll;
    logic [SW-1:0]                   loc_sum;
    logic [SW-1:0]                   char_sum;
    logic [SW-1:0]                   rd_sum;
    logic [AW-1:0]                   char_addr;
    logic [AW-1:0]                   rd_addr;
    logic [AW:0]                     top_sum;
    logic [AW-1:0]                   top_base_next;
    logic                            rd_in_range;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [tccw_pkg::CELL_W-1:0]     ram_wdata;
    logic [tccw_pkg::CELL_W-1:0]     ram_rdata;
    logic                            out_free;

    assign in_action = s_tdata[1:0];
    assign in_char   = s_tdata[9:2];
    assign in_idx    = s_tdata[20:10];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Cursor update for a character item
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        put_char = 1'b0;
        priority case (in_char)
            tccw_pkg::CH_BS: begin
                if (col_reg != '0) begin
                    col_next = col_reg - CW'(1);
                end
            end
            tccw_pkg::CH_TAB: begin
                col_next = (col_reg + CW'(8)) & ~CW'(7);
            end
            tccw_pkg::CH_CR: begin
                col_next = '0;
            end
            tccw_pkg::CH_LF: begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            default: begin
                if (in_char >= tccw_pkg::CH_SPACE && in_char <= tccw_pkg::CH_PRINT_MAX) begin
                    put_char = 1'b1;
                    col_next = col_reg + CW'(1);
                end
            end
        endcase
        if (col_next >= CW'(COLUMNS)) begin
            col_next = '0;
            row_next = row_next + RW'(1);
        end
        scroll = (row_next == RW'(ROWS));
        if (scroll) begin
            row_next = RW'(ROWS - 1);
        end
    end

    // Linear cursor location reported with the result
    always_comb begin
        unique case (in_action)
            tccw_pkg::ACT_WRITE: loc_sum = SW'(row_next) * SW'(COLUMNS) + SW'(col_next);
            tccw_pkg::ACT_CLEAR: loc_sum = '0;
            default:             loc_sum = SW'(row_reg) * SW'(COLUMNS) + SW'(col_reg);
        endcase
    end

    // Logical to physical cell address: rows form a ring starting at top_base
    always_comb begin
        char_sum = SW'(row_reg) * SW'(COLUMNS) + SW'(col_reg) + SW'(top_base_reg);
        if (char_sum >= SW'(CELLS)) begin
            char_sum = char_sum - SW'(CELLS);
        end
        char_addr = char_sum[AW-1:0];

        rd_sum = SW'(in_idx) + SW'(top_base_reg);
        if (rd_sum >= SW'(CELLS)) begin
            rd_sum = rd_sum - SW'(CELLS);
        end
        rd_addr     = rd_sum[AW-1:0];
        rd_in_range = (SW'(in_idx) < SW'(CELLS));

        top_sum = (AW + 1)'(top_base_reg) + (AW + 1)'(COLUMNS);
        if (top_sum >= (AW + 1)'(CELLS)) begin
            top_sum = top_sum - (AW + 1)'(CELLS);
        end
        top_base_next = top_sum[AW-1:0];
    end

    // RAM write port: fill pass, blank sweeps, character stores
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sweep_addr_reg;
        ram_wdata = {bg_reg, fg_reg, tccw_pkg::CH_SPACE};
        priority if (state_reg == ST_INIT) begin
            ram_we    = 1'b1;
            ram_wdata = tccw_pkg::RESET_CELL;
        end else if (state_reg == ST_SWEEP) begin
            ram_we = 1'b1;
        end else if (accept && in_action == tccw_pkg::ACT_WRITE && put_char) begin
            ram_we    = 1'b1;
            ram_waddr = char_addr;
            ram_wdata = {bg_reg, fg_reg, in_char};
        end else begin
            ram_we = 1'b0;
        end
    end

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept && in_action == tccw_pkg::ACT_READ),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= tccw_pkg::FG_RESET;
            bg_reg <= tccw_pkg::BG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tccw_pkg::REG_FG: fg_reg <= cfg_data;
                tccw_pkg::REG_BG: bg_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer, cursor and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            top_base_reg   <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(CELLS - 1);
            m_tvalid_reg   <= 1'b0;
        end else begin
            // a load in ST_DONE sets valid again below
            if (m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT, ST_SWEEP: begin
                    sweep_addr_reg <= sweep_addr_reg + AW'(1);
                    if (sweep_addr_reg == sweep_last_reg) begin
                        state_reg <= (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        res_loc_reg <= loc_sum[tccw_pkg::LOC_W-1:0];
                        res_rd_reg  <= (in_action == tccw_pkg::ACT_READ) && rd_in_range;
                        res_scr_reg <= (in_action == tccw_pkg::ACT_WRITE) && scroll;
                        unique case (in_action)
                            tccw_pkg::ACT_WRITE: begin
                                col_reg <= col_next;
                                row_reg <= row_next;
                                if (scroll) begin
                                    // old top row becomes the new, blank, last row
                                    top_base_reg   <= top_base_next;
                                    sweep_addr_reg <= top_base_reg;
                                    sweep_last_reg <= top_base_reg + AW'(COLUMNS - 1);
                                    state_reg      <= ST_SWEEP;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            tccw_pkg::ACT_CLEAR: begin
                                col_reg        <= '0;
                                row_reg        <= '0;
                                top_base_reg   <= '0;
                                sweep_addr_reg <= '0;
                                sweep_last_reg <= AW'(CELLS - 1);
                                state_reg      <= ST_SWEEP;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {PAD_W'(0), res_scr_reg,
                                         res_rd_reg ? ram_rdata : tccw_pkg::CELL_W'(0),
                                         res_loc_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_INIT;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tccw_checker.sv -----
`default_nettype none

module tccw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [tccw_pkg::S_DATA_W-1:0]   s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [tccw_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int  CELLS  = COLUMNS * ROWS;
    localparam bit  LOC_OK = (CELLS <= 2048);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // Fill pass after reset blocks input
    a_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready)
        else $error("input ready during fill pass");

    // Cursor stays on the screen
    a_loc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !LOC_OK || m_tdata[10:0] < CELLS)
        else $error("cursor location off screen");

    // A scroll leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> !LOC_OK || m_tdata[10:0] >= (ROWS - 1) * COLUMNS)
        else $error("scroll without cursor on last row");

    logic unused_ok;
    assign unused_ok = ^s_tdata;

endmodule

bind text_console_char_writer_unit tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
